FILE: design/dcsd_pkg.sv
package dcsd_pkg;

    localparam int POS_W = 32;
    localparam int CMD_W = 32;

    typedef enum logic [2:0] {
        PH_ADD_HDR  = 3'd0,
        PH_ADD_EXT  = 3'd1,
        PH_COPY_HDR = 3'd2,
        PH_COPY_LEN = 3'd3,
        PH_COPY_OFF = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_COPY = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CMD_W-1:0]   offset;
        logic [CMD_W-1:0]   length;
    } t_cmd;

    function automatic logic [CMD_W-1:0] add_bias(input logic [1:0] cls);
        logic [CMD_W-1:0] v;
        case (cls)
            2'd0:    v = CMD_W'(0);
            2'd1:    v = CMD_W'(32'h40);
            2'd2:    v = CMD_W'(32'h40 + 32'h4000);
            default: v = CMD_W'(32'h40 + 32'h4000 + 32'h40_0000);
        endcase
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] copy_len_bias(input logic [1:0] cls);
        logic [CMD_W-1:0] v;
        case (cls)
            2'd0:    v = CMD_W'(0);
            2'd1:    v = CMD_W'(32'h10);
            2'd2:    v = CMD_W'(32'h10 + 32'h1000);
            default: v = CMD_W'(32'h10 + 32'h1000 + 32'h10_0000);
        endcase
        return v;
    endfunction

    // top class repeats the one below it
    function automatic logic [POS_W-1:0] copy_off_bias(input logic [1:0] cls);
        logic [POS_W-1:0] v;
        case (cls)
            2'd0:    v = POS_W'(0);
            2'd1:    v = POS_W'(32'h80);
            default: v = POS_W'(32'h80 + 32'h8000);
        endcase
        return v;
    endfunction

endpackage

FILE: design/dcsd_parser.sv
module dcsd_parser
    import dcsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_load,
    input  logic [CMD_W-1:0] i_cfg_base,
    output logic             o_res_vld,
    output t_cmd             o_res
);

    t_phase           r_phase, n_phase;
    logic [2:0]       r_rem, n_rem;
    logic [1:0]       r_len_cls, n_len_cls;
    logic [1:0]       r_off_cls, n_off_cls;
    logic [CMD_W-1:0] r_len_acc, n_len_acc;
    logic [CMD_W-1:0] r_off_acc, n_off_acc;
    logic             r_neg, n_neg;
    logic [POS_W-1:0] r_copy_base, n_copy_base;
    logic [POS_W-1:0] r_base_adj, n_base_adj;
    logic [POS_W-1:0] r_add_pos;
    logic             r_pend_vld, n_pend_vld;
    logic [CMD_W-1:0] r_pend_len, n_pend_len;
    logic             r_finished, n_finished;

    logic [CMD_W-1:0] acc_sh;
    logic [CMD_W-1:0] add_len;
    logic [2:0]       rem_dec;
    logic             first_off;
    logic             neg_sel;
    logic [POS_W-1:0] base_sel;
    logic [POS_W-1:0] off_ext;
    logic [POS_W-1:0] src;
    logic [POS_W-1:0] bias_off;

    always_comb begin
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_len_cls   = r_len_cls;
        n_off_cls   = r_off_cls;
        n_len_acc   = r_len_acc;
        n_off_acc   = r_off_acc;
        n_neg       = r_neg;
        n_copy_base = r_copy_base;
        n_base_adj  = r_base_adj;
        n_pend_vld  = 1'b0;
        n_pend_len  = r_pend_len;
        n_finished  = r_finished;
        o_res_vld   = 1'b0;
        o_res       = '{kind: KIND_ADD, offset: '0, length: '0};

        acc_sh    = {r_len_acc[CMD_W-9:0], i_byte};
        rem_dec   = r_rem - 3'd1;
        first_off = (r_rem == ({1'b0, r_off_cls} + 3'd1));
        bias_off  = copy_off_bias(r_off_cls);
        add_len   = '0;
        neg_sel   = r_neg;
        base_sel  = r_base_adj;
        off_ext   = '0;
        src       = '0;

        if (!r_finished) begin
            unique case (r_phase)
                PH_ADD_HDR: begin
                    n_len_cls = i_byte[7:6];
                    n_len_acc = CMD_W'(i_byte[5:0]);
                    if (i_byte[7:6] == 2'd0) begin
                        add_len = CMD_W'(i_byte[5:0]);
                        n_phase = PH_COPY_HDR;
                        if (add_len != '0) begin
                            o_res_vld  = 1'b1;
                            o_res      = '{kind: KIND_ADD, offset: r_add_pos[CMD_W-1:0],
                                           length: add_len};
                            n_pend_vld = 1'b1;
                            n_pend_len = add_len;
                        end
                    end else begin
                        n_rem   = {1'b0, i_byte[7:6]};
                        n_phase = PH_ADD_EXT;
                    end
                end
                PH_ADD_EXT: begin
                    n_len_acc = acc_sh;
                    n_rem     = rem_dec;
                    if (rem_dec == 3'd0) begin
                        add_len = acc_sh + add_bias(r_len_cls);
                        n_phase = PH_COPY_HDR;
                        if (add_len != '0) begin
                            o_res_vld  = 1'b1;
                            o_res      = '{kind: KIND_ADD, offset: r_add_pos[CMD_W-1:0],
                                           length: add_len};
                            n_pend_vld = 1'b1;
                            n_pend_len = add_len;
                        end
                    end
                end
                PH_COPY_HDR: begin
                    n_len_cls = i_byte[7:6];
                    n_off_cls = i_byte[5:4];
                    n_len_acc = CMD_W'(i_byte[3:0]);
                    n_off_acc = '0;
                    n_neg     = 1'b0;
                    if (i_byte[7:6] != 2'd0) begin
                        n_rem   = {1'b0, i_byte[7:6]};
                        n_phase = PH_COPY_LEN;
                    end else begin
                        n_rem   = {1'b0, i_byte[5:4]} + 3'd1;
                        n_phase = PH_COPY_OFF;
                    end
                end
                PH_COPY_LEN: begin
                    n_len_acc = acc_sh;
                    n_rem     = rem_dec;
                    if (rem_dec == 3'd0) begin
                        n_len_acc = acc_sh + copy_len_bias(r_len_cls);
                        n_rem     = {1'b0, r_off_cls} + 3'd1;
                        n_phase   = PH_COPY_OFF;
                    end
                end
                PH_COPY_OFF: begin
                    // fold the class bias into the base on the first offset beat
                    if (first_off) begin
                        neg_sel    = i_byte[7];
                        base_sel   = r_copy_base;
                        n_neg      = i_byte[7];
                        n_off_acc  = CMD_W'(i_byte[6:0]);
                        n_base_adj = i_byte[7] ? (r_copy_base - bias_off)
                                               : (r_copy_base + bias_off);
                    end else begin
                        n_off_acc = {r_off_acc[CMD_W-9:0], i_byte};
                    end
                    n_rem = rem_dec;
                    if (rem_dec == 3'd0) begin
                        off_ext     = POS_W'(n_off_acc);
                        src         = neg_sel ? (base_sel - off_ext) : (base_sel + off_ext);
                        n_copy_base = src;
                        n_phase     = PH_ADD_HDR;
                        if (r_len_cls == 2'd0 && r_off_cls == 2'd0 &&
                            r_len_acc == '0 && src == '0) begin
                            n_finished = 1'b1;
                            o_res_vld  = 1'b1;
                            o_res      = '{kind: KIND_END, offset: '0, length: '0};
                        end else if (r_len_acc != '0) begin
                            o_res_vld = 1'b1;
                            o_res     = '{kind: KIND_COPY, offset: src[CMD_W-1:0],
                                          length: r_len_acc};
                        end
                    end
                end
                default: begin
                    n_phase = PH_ADD_HDR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ADD_HDR;
            r_rem       <= '0;
            r_len_cls   <= '0;
            r_off_cls   <= '0;
            r_len_acc   <= '0;
            r_off_acc   <= '0;
            r_neg       <= 1'b0;
            r_copy_base <= '0;
            r_base_adj  <= '0;
            r_finished  <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_len_cls   <= n_len_cls;
            r_off_cls   <= n_off_cls;
            r_len_acc   <= n_len_acc;
            r_off_acc   <= n_off_acc;
            r_neg       <= n_neg;
            r_copy_base <= n_copy_base;
            r_base_adj  <= n_base_adj;
            r_finished  <= n_finished;
        end
    end

    // the add position catches up through the pending register after each add; the next add is
    // at least a copy header and an offset beat away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_pos  <= '0;
            r_pend_vld <= 1'b0;
        end else if (i_cfg_load) begin
            r_add_pos  <= POS_W'(i_cfg_base);
            r_pend_vld <= 1'b0;
        end else begin
            if (r_pend_vld) begin
                r_add_pos <= r_add_pos + POS_W'(r_pend_len);
            end
            r_pend_vld <= i_adv && n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pend_len <= n_pend_len;
        end
    end

endmodule

FILE: design/dcsd_out_stage.sv
module dcsd_out_stage
    import dcsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_cmd i_cmd,
    input  logic i_stall,
    output logic o_free,
    output logic o_valid,
    output t_cmd o_cmd
);

    logic r_vld;
    t_cmd r_cmd;

    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

FILE: design/delta_command_stream_decoder.sv
// Delta patch command decoder: takes the command section one byte per beat and
// emits one beat per nonzero add (data position, length), per nonzero copy
// (absolute source, length) and one end beat, after which bytes are taken and
// dropped. Each byte is registered, decoded combinationally and its result lands
// in the output register, so a byte can be accepted every cycle; a result
// passes the input and output registers in turn. Throughput drops only while
// the output register holds a beat under stall. Writing the config register sets
// the add-data position; write it only idle.
module delta_command_stream_decoder
    import dcsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_patch_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_cmd_kind,
    output logic [CMD_W-1:0] o_cmd_offset,
    output logic [CMD_W-1:0] o_cmd_length,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CMD_W-1:0] i_cfg_data
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       in_acc;
    logic       adv;
    logic       res_vld;
    t_cmd       res;
    logic       out_free;
    t_cmd       out_cmd;
    logic       cfg_load;

    assign o_cfg_ready = 1'b1;
    assign cfg_load    = i_cfg_valid && o_cfg_ready;

    // advance unless a result would land on a stalled output beat
    assign adv        = r_in_vld && (out_free || !res_vld);
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_patch_byte;
        end
    end

    dcsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_byte     (r_in_byte),
        .i_cfg_load (cfg_load),
        .i_cfg_base (i_cfg_data),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    dcsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_vld),
        .i_cmd   (res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_cmd   (out_cmd)
    );

    assign o_cmd_kind   = out_cmd.kind;
    assign o_cmd_offset = out_cmd.offset;
    assign o_cmd_length = out_cmd.length;

endmodule
